// ===== rtl/csie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csie_pkg
// Shared constants and types for the instruction execute block: opcodes,
// register file layout, data store geometry, flag and status types.
// ----------------------------------------------------------------------------
package csie_pkg;

   localparam int ADDR_BITS   = 12;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;
   localparam int REG_COUNT   = 7;

   // register file slots: B C D E H L A
   localparam logic [2:0] RI_H = 3'd4;
   localparam logic [2:0] RI_L = 3'd5;
   localparam logic [2:0] RI_A = 3'd6;

   // operand codes inside the opcode
   localparam logic [2:0] CODE_M = 3'd6;
   localparam logic [2:0] CODE_A = 3'd7;

   localparam logic [7:0] OP_HLT = 8'h76;
   localparam logic [7:0] OP_ADI = 8'hC6;
   localparam logic [7:0] OP_ACI = 8'hCE;
   localparam logic [7:0] OP_LDA = 8'h3A;
   localparam logic [7:0] OP_STA = 8'h32;
   localparam logic [7:0] OP_OUT = 8'hD3;

   localparam logic [7:0] MASK_MVI = 8'hC7;
   localparam logic [7:0] BASE_MVI = 8'h06;
   localparam logic [7:0] MASK_MOV = 8'hC0;
   localparam logic [7:0] BASE_MOV = 8'h40;
   localparam logic [7:0] MASK_ADD = 8'hF8;
   localparam logic [7:0] BASE_ADD = 8'h80;
   localparam logic [7:0] BASE_ADC = 8'h88;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_HALTED  = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_PORT    = 2'd3
   } status_type;

   typedef struct packed {
      logic s;
      logic z;
      logic ac;
      logic p;
      logic cy;
   } flags_type;

   typedef struct packed {
      logic [7:0] sum;
      flags_type  flags;
   } alu_out_type;

endpackage

// ===== rtl/csie_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csie_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module csie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/csie_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csie_alu
// 8-bit adder with carry in, producing the sum and the S Z AC P CY flags.
// ----------------------------------------------------------------------------
module csie_alu (
   input  logic [7:0]            a,
   input  logic [7:0]            b,
   input  logic                  cin,
   output csie_pkg::alu_out_type result
);
   import csie_pkg::*;

   logic [8:0] sum_full;
   logic [4:0] sum_nibble;

   assign sum_full   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
   assign sum_nibble = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};

   always_comb begin
      result.sum      = sum_full[7:0];
      result.flags.s  = sum_full[7];
      result.flags.z  = (sum_full[7:0] == 8'd0);
      result.flags.ac = sum_nibble[4];
      // even parity sets P
      result.flags.p  = ~^sum_full[7:0];
      result.flags.cy = sum_full[8];
   end

endmodule

// ===== rtl/cpu_subset_instruction_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_subset_instruction_execute
// Executes one instruction of an 8-bit CPU subset per item and reports the
// register file, flags, program counter and status after it.
// ----------------------------------------------------------------------------
// Usage:
// - req channel carries opcode plus two immediate bytes; rsp channel carries
//   the architectural state after that instruction, one rsp item per req item.
// - rsp_valid rises after the item goes through execute and output registers.
// - throughput: one item per cycle sustained while rsp_stall is low. The data
//   store read for an item is issued on its accept edge, the write-back on
//   its retire edge; H/L are forwarded from the executing item into the read
//   address; a store write on the same edge as a read is forwarded to execute.
// - after reset the data store is swept to zero, one byte per cycle, over all
//   4096 addresses (2^ADDR_BITS); req_stall stays high during the sweep.
// - rsp_stall holds the output register; execute then holds its item and
//   req_stall goes high until the output register frees up.
// - once HLT executes, every later item reports the frozen state with
//   halted status until reset.
// ----------------------------------------------------------------------------
module cpu_subset_instruction_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_func,
   input  logic [7:0]  req_imm_low,
   input  logic [7:0]  req_imm_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_acc,
   output logic [7:0]  rsp_reg_b,
   output logic [7:0]  rsp_reg_c,
   output logic [7:0]  rsp_reg_d,
   output logic [7:0]  rsp_reg_e,
   output logic [7:0]  rsp_reg_h,
   output logic [7:0]  rsp_reg_l,
   output logic [7:0]  rsp_flag_bits,
   output logic [15:0] rsp_prog_counter,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_port_number
);
   import csie_pkg::*;

   typedef enum logic [3:0] {
      K_HLT, K_MVI, K_MOV, K_ADD, K_ADC, K_ADI, K_ACI,
      K_LDA, K_STA, K_OUT, K_BAD
   } kind_type;

   function automatic logic [2:0] reg_index(input logic [2:0] code);
      reg_index = (code == CODE_A) ? RI_A : code;
   endfunction

   function automatic kind_type decode(input logic [7:0] op);
      if (op == OP_HLT)                         decode = K_HLT;
      else if ((op & MASK_MVI) == BASE_MVI)     decode = K_MVI;
      else if ((op & MASK_MOV) == BASE_MOV)     decode = K_MOV;
      else if ((op & MASK_ADD) == BASE_ADD)     decode = K_ADD;
      else if ((op & MASK_ADD) == BASE_ADC)     decode = K_ADC;
      else if (op == OP_ADI)                    decode = K_ADI;
      else if (op == OP_ACI)                    decode = K_ACI;
      else if (op == OP_LDA)                    decode = K_LDA;
      else if (op == OP_STA)                    decode = K_STA;
      else if (op == OP_OUT)                    decode = K_OUT;
      else                                      decode = K_BAD;
   endfunction

   // architectural state
   logic [7:0]           regs_ff [REG_COUNT];
   logic [7:0]           regs_in [REG_COUNT];
   flags_type            flags_ff, flags_in;
   logic [15:0]          pc_ff, pc_in;
   logic                 halted_ff, halted_in;

   // store sweep after reset
   logic                 clearing_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;

   // execute stage
   logic                 e_valid_ff;
   logic [7:0]           e_func_ff;
   logic [7:0]           e_lo_ff;
   logic [ADDR_BITS-1:0] e_addr_ff;
   logic                 e_advance;
   logic                 accept;

   // store write forwarding
   logic                 fwd_valid_ff;
   logic [ADDR_BITS-1:0] fwd_addr_ff;
   logic [7:0]           fwd_data_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_acc_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;
   logic [7:0]           rsp_e_ff, rsp_h_ff, rsp_l_ff, rsp_flags_ff;
   logic [15:0]          rsp_pc_ff;
   status_type           rsp_status_ff;
   logic [7:0]           rsp_port_ff;

   // combinational
   kind_type             kind;
   logic [2:0]           src_code, dst_code;
   logic [7:0]           ram_rd, mem_rd, src_val;
   logic [7:0]           alu_b;
   logic                 alu_cin;
   alu_out_type          alu_res;
   logic                 mem_we;
   logic [7:0]           mem_wd;
   logic [1:0]           len;
   status_type           status;
   logic [7:0]           port;
   logic [15:0]          m_full, imm_full;
   logic [ADDR_BITS-1:0] new_addr, rd_addr;
   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   logic [7:0]           ram_wdata;

   assign e_advance = e_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = clearing_ff | (e_valid_ff & ~e_advance);
   assign accept    = req_valid & ~req_stall;

   // read address for the incoming item, H/L taken after the executing item
   assign m_full   = {regs_in[RI_H], regs_in[RI_L]};
   assign imm_full = {req_imm_high, req_imm_low};
   assign new_addr = (req_func == OP_LDA || req_func == OP_STA) ?
                     imm_full[ADDR_BITS-1:0] : m_full[ADDR_BITS-1:0];
   assign rd_addr  = (e_valid_ff & ~e_advance) ? e_addr_ff : new_addr;

   assign ram_we    = clearing_ff | (e_advance & mem_we);
   assign ram_waddr = clearing_ff ? clr_addr_ff : e_addr_ff;
   assign ram_wdata = clearing_ff ? 8'd0 : mem_wd;

   csie_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   // a write on the read edge is not seen by the ram read
   assign mem_rd = (fwd_valid_ff && fwd_addr_ff == e_addr_ff) ? fwd_data_ff : ram_rd;

   assign kind     = decode(e_func_ff);
   assign src_code = e_func_ff[2:0];
   assign dst_code = e_func_ff[5:3];
   assign src_val  = (src_code == CODE_M) ? mem_rd : regs_ff[reg_index(src_code)];
   assign alu_b    = (kind == K_ADI || kind == K_ACI) ? e_lo_ff : src_val;
   assign alu_cin  = (kind == K_ADC || kind == K_ACI) & flags_ff.cy;

   csie_alu u_alu (
      .a      (regs_ff[RI_A]),
      .b      (alu_b),
      .cin    (alu_cin),
      .result (alu_res)
   );

   always_comb begin
      regs_in   = regs_ff;
      flags_in  = flags_ff;
      halted_in = halted_ff;
      mem_we    = 1'b0;
      mem_wd    = regs_ff[RI_A];
      len       = 2'd1;
      status    = ST_DONE;
      port      = 8'd0;
      if (e_valid_ff) begin
         if (halted_ff) begin
            status = ST_HALTED;
            len    = 2'd0;
         end else begin
            unique case (kind)
               K_HLT: begin
                  halted_in = 1'b1;
                  status    = ST_HALTED;
               end
               K_MVI: begin
                  len = 2'd2;
                  if (dst_code == CODE_M) begin
                     mem_we = 1'b1;
                     mem_wd = e_lo_ff;
                  end else begin
                     regs_in[reg_index(dst_code)] = e_lo_ff;
                  end
               end
               K_MOV: begin
                  if (dst_code == CODE_M) begin
                     mem_we = 1'b1;
                     mem_wd = src_val;
                  end else begin
                     regs_in[reg_index(dst_code)] = src_val;
                  end
               end
               K_ADD, K_ADC, K_ADI, K_ACI: begin
                  regs_in[RI_A] = alu_res.sum;
                  flags_in      = alu_res.flags;
                  if (kind == K_ADI || kind == K_ACI) begin
                     len = 2'd2;
                  end
               end
               K_LDA: begin
                  regs_in[RI_A] = mem_rd;
                  len           = 2'd3;
               end
               K_STA: begin
                  mem_we = 1'b1;
                  len    = 2'd3;
               end
               K_OUT: begin
                  status = ST_PORT;
                  port   = e_lo_ff;
                  len    = 2'd2;
               end
               default: begin
                  status = ST_UNKNOWN;
               end
            endcase
         end
      end
      pc_in = pc_ff + {14'd0, len};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= 8'd0;
         end
         flags_ff      <= '0;
         pc_ff         <= 16'd0;
         halted_ff     <= 1'b0;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         e_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + {{(ADDR_BITS-1){1'b0}}, 1'b1};
            if (clr_addr_ff == {ADDR_BITS{1'b1}}) begin
               clearing_ff <= 1'b0;
            end
         end
         if (e_advance) begin
            regs_ff   <= regs_in;
            flags_ff  <= flags_in;
            pc_ff     <= pc_in;
            halted_ff <= halted_in;
         end
         if (accept) begin
            e_valid_ff <= 1'b1;
         end else if (e_advance) begin
            e_valid_ff <= 1'b0;
         end
         fwd_valid_ff <= e_advance & mem_we;
         if (e_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         e_func_ff <= req_func;
         e_lo_ff   <= req_imm_low;
         e_addr_ff <= new_addr;
      end
      fwd_addr_ff <= e_addr_ff;
      fwd_data_ff <= mem_wd;
      if (e_advance) begin
         rsp_acc_ff    <= regs_in[RI_A];
         rsp_b_ff      <= regs_in[0];
         rsp_c_ff      <= regs_in[1];
         rsp_d_ff      <= regs_in[2];
         rsp_e_ff      <= regs_in[3];
         rsp_h_ff      <= regs_in[RI_H];
         rsp_l_ff      <= regs_in[RI_L];
         rsp_flags_ff  <= {flags_in.s, flags_in.z, 1'b0, flags_in.ac,
                           1'b0, flags_in.p, 1'b1, flags_in.cy};
         rsp_pc_ff     <= pc_in;
         rsp_status_ff <= status;
         rsp_port_ff   <= port;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_acc          = rsp_acc_ff;
   assign rsp_reg_b        = rsp_b_ff;
   assign rsp_reg_c        = rsp_c_ff;
   assign rsp_reg_d        = rsp_d_ff;
   assign rsp_reg_e        = rsp_e_ff;
   assign rsp_reg_h        = rsp_h_ff;
   assign rsp_reg_l        = rsp_l_ff;
   assign rsp_flag_bits    = rsp_flags_ff;
   assign rsp_prog_counter = rsp_pc_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_port_number  = rsp_port_ff;

   // no item reaches execute while the store is being swept
   a_no_exec_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !e_valid_ff)
      else $error("item in execute during store sweep");

   // only reset leaves the halted state
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted mark cleared without reset");

   // pc moves only when an item retires
   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !e_advance |=> $stable(pc_ff))
      else $error("pc changed without a retiring item");

   // a halted core reports halted status
   a_halt_status: assert property (@(posedge clock) disable iff (reset)
      (e_advance && halted_ff) |=> (rsp_status == ST_HALTED))
      else $error("halted core reported non-halted status");

endmodule

// ===== sim/csie_state_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csie_state_checker
// Watches the req and rsp channels of the instruction execute block, keeps
// its own copy of the registers, flags, pc, halt mark and data store, and
// compares every rsp item field by field with the predicted state.
// ----------------------------------------------------------------------------
module csie_state_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_func,
   input  logic [7:0]  req_imm_low,
   input  logic [7:0]  req_imm_high,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_acc,
   input  logic [7:0]  rsp_reg_b,
   input  logic [7:0]  rsp_reg_c,
   input  logic [7:0]  rsp_reg_d,
   input  logic [7:0]  rsp_reg_e,
   input  logic [7:0]  rsp_reg_h,
   input  logic [7:0]  rsp_reg_l,
   input  logic [7:0]  rsp_flag_bits,
   input  logic [15:0] rsp_prog_counter,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_port_number,
   output int          fail_count,
   output int          pending_count
);
   import csie_pkg::*;

   typedef struct {
      logic [7:0]  acc;
      logic [7:0]  reg_b;
      logic [7:0]  reg_c;
      logic [7:0]  reg_d;
      logic [7:0]  reg_e;
      logic [7:0]  reg_h;
      logic [7:0]  reg_l;
      logic [7:0]  flag_bits;
      logic [15:0] prog_counter;
      status_type  status;
      logic [7:0]  port_number;
   } arch_state_type;

   logic [7:0]  regfile [REG_COUNT];
   flags_type   cpu_flags;
   logic [15:0] cpu_pc;
   logic        cpu_halted;
   logic [7:0]  store_bytes [STORE_DEPTH];

   arch_state_type state_after_queue [$];
   int mismatches = 0;
   int awaiting = 0;

   assign fail_count    = mismatches;
   assign pending_count = awaiting;

   function automatic logic [2:0] slot_of(logic [2:0] code);
      return (code == CODE_A) ? RI_A : code;
   endfunction

   function automatic logic [ADDR_BITS-1:0] hl_address();
      logic [15:0] hl;
      hl = {regfile[RI_H], regfile[RI_L]};
      return hl[ADDR_BITS-1:0];
   endfunction

   function automatic logic [7:0] operand_read(logic [2:0] code);
      if (code == CODE_M) begin
         return store_bytes[hl_address()];
      end
      return regfile[slot_of(code)];
   endfunction

   task automatic operand_write(input logic [2:0] code, input logic [7:0] value);
      if (code == CODE_M) begin
         store_bytes[hl_address()] = value;
      end else begin
         regfile[slot_of(code)] = value;
      end
   endtask

   task automatic accumulate(input logic [7:0] addend, input logic carry_in);
      logic [8:0] total;
      logic [4:0] low_nibble;
      logic [7:0] a;
      a          = regfile[RI_A];
      total      = {1'b0, a} + {1'b0, addend} + {8'd0, carry_in};
      low_nibble = {1'b0, a[3:0]} + {1'b0, addend[3:0]} + {4'd0, carry_in};
      cpu_flags.s  = total[7];
      cpu_flags.z  = (total[7:0] == 8'd0);
      cpu_flags.ac = low_nibble[4];
      cpu_flags.p  = ~^total[7:0];
      cpu_flags.cy = total[8];
      regfile[RI_A] = total[7:0];
   endtask

   task automatic execute_instruction(input logic [7:0] op, input logic [7:0] lo,
                                      input logic [7:0] hi, output arch_state_type st);
      logic [15:0] direct;
      logic [ADDR_BITS-1:0] direct_addr;
      logic [15:0] length;
      status_type  status;
      logic [7:0]  port;
      direct      = {hi, lo};
      direct_addr = direct[ADDR_BITS-1:0];
      length      = 16'd1;
      status      = ST_DONE;
      port        = 8'd0;
      if (cpu_halted) begin
         status = ST_HALTED;
         length = 16'd0;
      end else if (op == OP_HLT) begin
         cpu_halted = 1'b1;
         status     = ST_HALTED;
      end else if ((op & MASK_MVI) == BASE_MVI) begin
         operand_write(op[5:3], lo);
         length = 16'd2;
      end else if ((op & MASK_MOV) == BASE_MOV) begin
         operand_write(op[5:3], operand_read(op[2:0]));
      end else if ((op & MASK_ADD) == BASE_ADD) begin
         accumulate(operand_read(op[2:0]), 1'b0);
      end else if ((op & MASK_ADD) == BASE_ADC) begin
         accumulate(operand_read(op[2:0]), cpu_flags.cy);
      end else if (op == OP_ADI) begin
         accumulate(lo, 1'b0);
         length = 16'd2;
      end else if (op == OP_ACI) begin
         accumulate(lo, cpu_flags.cy);
         length = 16'd2;
      end else if (op == OP_LDA) begin
         regfile[RI_A] = store_bytes[direct_addr];
         length = 16'd3;
      end else if (op == OP_STA) begin
         store_bytes[direct_addr] = regfile[RI_A];
         length = 16'd3;
      end else if (op == OP_OUT) begin
         status = ST_PORT;
         port   = lo;
         length = 16'd2;
      end else begin
         status = ST_UNKNOWN;
      end
      cpu_pc = cpu_pc + length;

      st.acc          = regfile[RI_A];
      st.reg_b        = regfile[0];
      st.reg_c        = regfile[1];
      st.reg_d        = regfile[2];
      st.reg_e        = regfile[3];
      st.reg_h        = regfile[RI_H];
      st.reg_l        = regfile[RI_L];
      st.flag_bits    = {cpu_flags.s, cpu_flags.z, 1'b0, cpu_flags.ac, 1'b0,
                         cpu_flags.p, 1'b1, cpu_flags.cy};
      st.prog_counter = cpu_pc;
      st.status       = status;
      st.port_number  = port;
   endtask

   function automatic int field_differs(string label, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %h actual %h", $time, label, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      arch_state_type predicted;
      arch_state_type want;
      if (reset) begin
         foreach (regfile[i]) regfile[i] = 8'd0;
         foreach (store_bytes[i]) store_bytes[i] = 8'd0;
         cpu_flags  = '0;
         cpu_pc     = 16'd0;
         cpu_halted = 1'b0;
         state_after_queue.delete();
      end else begin
         // retire before predicting so a same-edge req never pairs with its own rsp
         if (rsp_valid && !rsp_stall) begin
            if (state_after_queue.size() == 0) begin
               $display("%0t mismatch rsp item with nothing expected", $time);
               mismatches++;
            end else begin
               want = state_after_queue.pop_front();
               mismatches += field_differs("acc", 16'(want.acc), 16'(rsp_acc));
               mismatches += field_differs("reg_b", 16'(want.reg_b), 16'(rsp_reg_b));
               mismatches += field_differs("reg_c", 16'(want.reg_c), 16'(rsp_reg_c));
               mismatches += field_differs("reg_d", 16'(want.reg_d), 16'(rsp_reg_d));
               mismatches += field_differs("reg_e", 16'(want.reg_e), 16'(rsp_reg_e));
               mismatches += field_differs("reg_h", 16'(want.reg_h), 16'(rsp_reg_h));
               mismatches += field_differs("reg_l", 16'(want.reg_l), 16'(rsp_reg_l));
               mismatches += field_differs("flag_bits", 16'(want.flag_bits),
                                           16'(rsp_flag_bits));
               mismatches += field_differs("prog_counter", want.prog_counter,
                                           rsp_prog_counter);
               mismatches += field_differs("status", 16'(want.status), 16'(rsp_status));
               mismatches += field_differs("port_number", 16'(want.port_number),
                                           16'(rsp_port_number));
            end
         end
         if (req_valid && !req_stall) begin
            execute_instruction(req_func, req_imm_low, req_imm_high, predicted);
            state_after_queue.push_back(predicted);
         end
      end
      awaiting = state_after_queue.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives instruction items into the execute block with random gaps and
// random rsp back-pressure: a directed opening, a long random run weighted
// toward well-formed instructions with colliding memory addresses, and a
// halt at the end. The checker predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module testbench;
   import csie_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_func = 8'd0;
   logic [7:0]  req_imm_low = 8'd0;
   logic [7:0]  req_imm_high = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_acc;
   logic [7:0]  rsp_reg_b;
   logic [7:0]  rsp_reg_c;
   logic [7:0]  rsp_reg_d;
   logic [7:0]  rsp_reg_e;
   logic [7:0]  rsp_reg_h;
   logic [7:0]  rsp_reg_l;
   logic [7:0]  rsp_flag_bits;
   logic [15:0] rsp_prog_counter;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_port_number;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   bit no_idle = 1'b0;

   cpu_subset_instruction_execute u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_imm_low      (req_imm_low),
      .req_imm_high     (req_imm_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_acc          (rsp_acc),
      .rsp_reg_b        (rsp_reg_b),
      .rsp_reg_c        (rsp_reg_c),
      .rsp_reg_d        (rsp_reg_d),
      .rsp_reg_e        (rsp_reg_e),
      .rsp_reg_h        (rsp_reg_h),
      .rsp_reg_l        (rsp_reg_l),
      .rsp_flag_bits    (rsp_flag_bits),
      .rsp_prog_counter (rsp_prog_counter),
      .rsp_status       (rsp_status),
      .rsp_port_number  (rsp_port_number)
   );

   csie_state_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_imm_low      (req_imm_low),
      .req_imm_high     (req_imm_high),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_acc          (rsp_acc),
      .rsp_reg_b        (rsp_reg_b),
      .rsp_reg_c        (rsp_reg_c),
      .rsp_reg_d        (rsp_reg_d),
      .rsp_reg_e        (rsp_reg_e),
      .rsp_reg_h        (rsp_reg_h),
      .rsp_reg_l        (rsp_reg_l),
      .rsp_flag_bits    (rsp_flag_bits),
      .rsp_prog_counter (rsp_prog_counter),
      .rsp_status       (rsp_status),
      .rsp_port_number  (rsp_port_number),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the accept
   task automatic send_instruction(input logic [7:0] op, input logic [7:0] lo,
                                   input logic [7:0] hi);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= op;
      req_imm_low  <= lo;
      req_imm_high <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // upper nibble is masked off by the store width; low nibble keeps pages few
   function automatic logic [7:0] pick_page();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return {4'($urandom_range(0, 15)), 4'($urandom_range(0, 1))};
   endfunction

   function automatic logic [7:0] pick_offset();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 8'hFF : 8'h00);
   endfunction

   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h0F;
         3: return 8'hFF;
         4: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin : result_sink
      int hold;
      @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 18);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [7:0] op;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [2:0] dst;
      logic [2:0] src;
      int         pick;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: carries, flags, M addressing at the store edge, masking
      send_instruction(8'h3E, 8'hFF, 8'h00);           // mvi a,ff
      send_instruction(OP_ADI, 8'h01, 8'hFF);          // wraps to zero with carry
      send_instruction(OP_ACI, 8'h00, 8'h00);          // carry in
      send_instruction(8'h06, 8'h80, 8'h00);           // mvi b,80
      send_instruction(BASE_ADC, 8'h00, 8'h00);        // adc b
      send_instruction(8'h26, 8'hFF, 8'h00);           // mvi h,ff
      send_instruction(8'h2E, 8'hFF, 8'h00);           // mvi l,ff
      send_instruction(8'h36, 8'h5A, 8'h00);           // mvi m
      send_instruction(BASE_ADD | {5'd0, CODE_M}, 8'h00, 8'h00);
      send_instruction(8'h4E, 8'h00, 8'h00);           // mov c,m
      send_instruction(8'h77, 8'h00, 8'h00);           // mov m,a
      send_instruction(8'h51, 8'h00, 8'h00);           // mov d,c
      send_instruction(8'h5F, 8'h00, 8'h00);           // mov e,a
      send_instruction(8'h7B, 8'h00, 8'h00);           // mov a,e
      send_instruction(BASE_ADD | {5'd0, CODE_A}, 8'hFF, 8'hFF);
      send_instruction(BASE_ADC | {5'd0, CODE_M}, 8'h00, 8'h00);
      send_instruction(OP_STA, 8'hFF, 8'hFF);          // address above store size
      send_instruction(8'h3E, 8'h00, 8'h00);           // clear a
      send_instruction(OP_LDA, 8'hFF, 8'h0F);          // same byte after masking
      send_instruction(OP_STA, 8'h00, 8'h00);
      send_instruction(OP_LDA, 8'h00, 8'hF0);
      send_instruction(OP_OUT, 8'hFF, 8'h00);
      send_instruction(OP_OUT, 8'h00, 8'hFF);
      send_instruction(8'h00, 8'hFF, 8'hFF);           // unknown opcodes
      send_instruction(8'hFF, 8'h00, 8'h00);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         lo   = 8'($urandom);
         hi   = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            dst = 3'($urandom_range(0, 7));
            op  = {2'b00, dst, 3'b110};
            if (dst == RI_H) lo = pick_page();
            else if (dst == RI_L) lo = pick_offset();
            else lo = pick_data();
         end else if (pick < 35) begin
            dst = 3'($urandom_range(0, 7));
            src = 3'($urandom_range(0, 7));
            // mov m,m is the halt opcode
            if (dst == CODE_M && src == CODE_M) src = CODE_A;
            op = {2'b01, dst, src};
         end else if (pick < 50) begin
            src = 3'($urandom_range(0, 7));
            op  = ($urandom_range(0, 1) ? BASE_ADC : BASE_ADD) | {5'd0, src};
         end else if (pick < 65) begin
            op = $urandom_range(0, 1) ? OP_ACI : OP_ADI;
            lo = pick_data();
         end else if (pick < 85) begin
            op = (pick < 75) ? OP_LDA : OP_STA;
            lo = pick_offset();
            hi = pick_page();
         end else if (pick < 90) begin
            op = OP_OUT;
         end else begin
            op = 8'($urandom);
            if (op == OP_HLT) op = 8'h00;
         end
         send_instruction(op, lo, hi);
      end

      // halt last: after it every item must report the frozen state
      no_idle = 1'b0;
      wait_for_drain();
      send_instruction(OP_HLT, 8'($urandom), 8'($urandom));
      send_instruction(8'h3E, 8'h12, 8'h00);
      send_instruction(OP_STA, 8'h00, 8'h00);
      send_instruction(OP_ADI, 8'hFF, 8'h00);
      send_instruction(OP_HLT, 8'h00, 8'h00);
      for (int n = 0; n < 4; n++) begin
         send_instruction(8'($urandom), 8'($urandom), 8'($urandom));
      end

      wait_for_drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
